// ===== hdl/hmsn_pkg.sv =====
`default_nettype none
package hmsn_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GRID_ROWS  = 2'd0;
  localparam logic [1:0] CFG_GRID_COLS  = 2'd1;
  localparam logic [1:0] CFG_SLOPE_GAIN = 2'd2;

  // Item modes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Neighbor read selectors.
  typedef enum logic [1:0] {
    NB_UP    = 2'd0,
    NB_DOWN  = 2'd1,
    NB_LEFT  = 2'd2,
    NB_RIGHT = 2'd3
  } nb_sel_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic    load;
    logic    mem_wr;
    logic    mem_rd;
    nb_sel_t rd_sel;
    logic    cap_en;
    nb_sel_t cap_sel;
    logic    mul_go;
    logic    shift_go;
    logic    sqrt_go;
    logic    div_go;
    logic    out_load;
    logic    out_zero;
  } hmsn_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic mode;
    logic oob;
    logic shift_done;
    logic sqrt_done;
    logic div_done;
  } hmsn_sts_t;

endpackage
`default_nettype wire

// ===== hdl/hmsn_ram.sv =====
`default_nettype none
module hmsn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== hdl/hmsn_ctrl.sv =====
`default_nettype none
module hmsn_ctrl
  import hmsn_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      hmsn_cmd_t cmd,
  input  wire hmsn_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_CAP3,
    ST_MUL, ST_SHIFT, ST_SQRT, ST_DIV, ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;
  // A new item may enter once the result register is free to be refilled.
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.oob || sts.mode == MODE_WRITE) begin
          cmd.mem_wr    = !sts.oob;
          cmd.out_load  = 1'b1;
          cmd.out_zero  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = NB_UP;
          state_nxt  = ST_RD0;
        end
      end
      ST_RD0: begin
        cmd.mem_rd = 1'b1; cmd.rd_sel = NB_DOWN;
        cmd.cap_en = 1'b1; cmd.cap_sel = NB_UP;
        state_nxt  = ST_RD1;
      end
      ST_RD1: begin
        cmd.mem_rd = 1'b1; cmd.rd_sel = NB_LEFT;
        cmd.cap_en = 1'b1; cmd.cap_sel = NB_DOWN;
        state_nxt  = ST_RD2;
      end
      ST_RD2: begin
        cmd.mem_rd = 1'b1; cmd.rd_sel = NB_RIGHT;
        cmd.cap_en = 1'b1; cmd.cap_sel = NB_LEFT;
        state_nxt  = ST_RD3;
      end
      ST_RD3: begin
        cmd.cap_en = 1'b1; cmd.cap_sel = NB_RIGHT;
        state_nxt  = ST_CAP3;
      end
      ST_CAP3: begin
        cmd.mul_go = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        cmd.shift_go = 1'b1;
        state_nxt    = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (sts.shift_done) begin
          cmd.sqrt_go = 1'b1;
          state_nxt   = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.div_go = 1'b1;
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and result-valid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hmsn_dp.sv =====
`default_nettype none
module hmsn_dp
  import hmsn_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire hmsn_cmd_t   cmd,
  output      hmsn_sts_t   sts,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_row,
  input  wire logic [7:0]  in_col,
  input  wire logic [15:0] in_height,
  input  wire logic [8:0]  grid_rows,
  input  wire logic [8:0]  grid_cols,
  input  wire logic [15:0] slope_gain,
  output      logic        out_status,
  output      logic [15:0] out_normal_x,
  output      logic [14:0] out_normal_y,
  output      logic [15:0] out_normal_z
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = RW + CW;
  localparam int SW = (RW > 9 ? RW : 9) + 1;
  localparam int CSW = (CW > 9 ? CW : 9) + 1;

  // Item capture.
  logic        mode_r;
  logic [7:0]  row_r, col_r;
  logic [15:0] height_r;
  logic [SW-1:0]  nr_r;
  logic [CSW-1:0] nc_r;
  logic [SW-1:0]  nr_nxt;
  logic [CSW-1:0] nc_nxt;

  // Effective grid size: zero acts as one, large values saturate.
  always_comb begin
    nr_nxt = SW'(grid_rows);
    if (grid_rows == 9'd0) nr_nxt = SW'(1);
    else if (SW'(grid_rows) > SW'(MAX_ROWS)) nr_nxt = SW'(MAX_ROWS);
    nc_nxt = CSW'(grid_cols);
    if (grid_cols == 9'd0) nc_nxt = CSW'(1);
    else if (CSW'(grid_cols) > CSW'(MAX_COLS)) nc_nxt = CSW'(MAX_COLS);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      row_r    <= in_row;
      col_r    <= in_col;
      height_r <= in_height;
      nr_r     <= nr_nxt;
      nc_r     <= nc_nxt;
    end
  end

  logic [SW-1:0]  r_w;
  logic [CSW-1:0] c_w;
  assign r_w = SW'(row_r);
  assign c_w = CSW'(col_r);

  logic oob;
  assign oob = (r_w >= nr_r) || (c_w >= nc_r);

  // Clamped neighbor coordinates.
  logic [SW-1:0]  rm, rp;
  logic [CSW-1:0] cm, cp;
  assign rm = (r_w == '0) ? '0 : r_w - SW'(1);
  assign rp = (r_w + SW'(1) >= nr_r) ? nr_r - SW'(1) : r_w + SW'(1);
  assign cm = (c_w == '0) ? '0 : c_w - CSW'(1);
  assign cp = (c_w + CSW'(1) >= nc_r) ? nc_r - CSW'(1) : c_w + CSW'(1);

  logic row_edge, col_edge;
  assign row_edge = (r_w == '0) || (r_w == nr_r - SW'(1));
  assign col_edge = (c_w == '0) || (c_w == nc_r - CSW'(1));

  // Memory address mux.
  logic [AW-1:0] addr;
  logic [15:0]   rdata;
  always_comb begin
    unique case (cmd.rd_sel)
      NB_UP:    addr = {rm[RW-1:0], c_w[CW-1:0]};
      NB_DOWN:  addr = {rp[RW-1:0], c_w[CW-1:0]};
      NB_LEFT:  addr = {r_w[RW-1:0], cm[CW-1:0]};
      NB_RIGHT: addr = {r_w[RW-1:0], cp[CW-1:0]};
      default:  addr = {r_w[RW-1:0], c_w[CW-1:0]};
    endcase
    if (cmd.mem_wr) addr = {r_w[RW-1:0], c_w[CW-1:0]};
  end

  hmsn_ram #(.WIDTH(16), .DEPTH(MAX_ROWS * MAX_COLS)) u_ram (
    .clk   (clk),
    .we    (cmd.mem_wr),
    .addr  (addr),
    .wdata (height_r),
    .rdata (rdata)
  );

  // Neighbor capture.
  logic signed [15:0] h_up_r, h_dn_r, h_lf_r, h_rt_r;
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        NB_UP:   h_up_r <= rdata;
        NB_DOWN: h_dn_r <= rdata;
        NB_LEFT: h_lf_r <= rdata;
        default: h_rt_r <= rdata;
      endcase
    end
  end

  // Differences and slope products (18 x 17 bits signed).
  logic signed [17:0] dx, dy;
  assign dx = row_edge ? ((18'(h_up_r) - 18'(h_dn_r)) <<< 1) : (18'(h_up_r) - 18'(h_dn_r));
  assign dy = col_edge ? ((18'(h_rt_r) - 18'(h_lf_r)) <<< 1) : (18'(h_rt_r) - 18'(h_lf_r));

  logic signed [16:0] gain_s;
  assign gain_s = $signed({1'b0, slope_gain});

  logic [34:0] ma_r, mb_r, one_r;
  logic        a_pos_r, b_pos_r;
  logic signed [34:0] pa, pb;
  assign pa = 35'(dx) * 35'(gain_s);
  assign pb = 35'(dy) * 35'(gain_s);

  // Normalizing shift: one position per cycle until the larger magnitude fits 30 bits.
  logic shift_busy_r, shift_done;
  assign shift_done = !shift_busy_r && !cmd.shift_go;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_busy_r <= 1'b0;
    end else if (cmd.mul_go) begin
      ma_r    <= pa[34] ? 35'(-pa) : pa;
      mb_r    <= pb[34] ? 35'(-pb) : pb;
      one_r   <= 35'(1) << 16;
      a_pos_r <= !pa[34] && (pa != '0);
      b_pos_r <= !pb[34] && (pb != '0);
    end else if (cmd.shift_go) begin
      shift_busy_r <= 1'b1;
    end else if (shift_busy_r) begin
      if ((ma_r[34:30] != '0) || (mb_r[34:30] != '0)) begin
        ma_r  <= ma_r >> 1;
        mb_r  <= mb_r >> 1;
        one_r <= one_r >> 1;
      end else begin
        shift_busy_r <= 1'b0;
      end
    end
  end

  // Sum of squares, one square per cycle through a 30x30 multiplier.
  logic [1:0]  sq_idx_r;
  logic [29:0] sq_op;
  logic [59:0] sq_prod_r;
  logic [61:0] sum_r;
  logic [2:0]  sq_cnt_r;
  always_comb begin
    case (sq_idx_r)
      2'd0:    sq_op = ma_r[29:0];
      2'd1:    sq_op = mb_r[29:0];
      default: sq_op = one_r[29:0];
    endcase
  end

  // Integer square root, one result bit per cycle.
  logic        sqrt_busy_r;
  logic [4:0]  sqrt_cnt_r;
  logic [61:0] rem_r;
  logic [61:0] sq_s_r;
  logic [30:0] root_r;
  logic [63:0] trial;
  logic [63:0] rem_sh;
  assign rem_sh = {rem_r, sq_s_r[61:60]};
  assign trial  = {31'd0, root_r, 2'b01};

  logic sqrt_done;
  assign sqrt_done = !sqrt_busy_r && (sq_cnt_r == 3'd0) && !cmd.sqrt_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r    <= 3'd0;
      sqrt_busy_r <= 1'b0;
    end else if (cmd.sqrt_go) begin
      sq_cnt_r  <= 3'd4;
      sq_idx_r  <= 2'd0;
      sum_r     <= '0;
    end else if (sq_cnt_r != 3'd0) begin
      sq_prod_r <= sq_op * sq_op;
      sq_idx_r  <= sq_idx_r + 2'd1;
      if (sq_cnt_r != 3'd4) sum_r <= sum_r + 62'(sq_prod_r);
      sq_cnt_r  <= sq_cnt_r - 3'd1;
      if (sq_cnt_r == 3'd1) begin
        sq_s_r      <= sum_r + 62'(sq_prod_r);
        rem_r       <= '0;
        root_r      <= '0;
        sqrt_cnt_r  <= 5'd30;
        sqrt_busy_r <= 1'b1;
      end
    end else if (sqrt_busy_r) begin
      if (rem_sh >= trial) begin
        rem_r  <= 62'(rem_sh - trial);
        root_r <= {root_r[29:0], 1'b1};
      end else begin
        rem_r  <= 62'(rem_sh);
        root_r <= {root_r[29:0], 1'b0};
      end
      sq_s_r <= sq_s_r << 2;
      if (sqrt_cnt_r == 5'd0) sqrt_busy_r <= 1'b0;
      else sqrt_cnt_r <= sqrt_cnt_r - 5'd1;
    end
  end

  // Restoring divider shared by the three components, one quotient bit per cycle.
  logic        div_busy_r;
  logic [1:0]  div_idx_r;
  logic [1:0]  div_sel;
  logic [5:0]  div_cnt_r;
  logic [30:0] len;
  logic [44:0] num_r;
  logic [31:0] drem_r;
  logic [44:0] quo_r;
  logic [31:0] drem_sh;
  logic [15:0] qx_r, qy_r, qz_r;
  logic [14:0] qsat;
  logic [29:0] div_mag;
  assign len     = (root_r == '0) ? 31'd1 : root_r;
  assign drem_sh = {drem_r[30:0], num_r[44]};
  assign qsat    = (quo_r > 45'd16384) ? 15'd16384 : quo_r[14:0];
  // The first component is selected directly when a division starts.
  assign div_sel = cmd.div_go ? 2'd0 : div_idx_r;
  always_comb begin
    case (div_sel)
      2'd0:    div_mag = mb_r[29:0];
      2'd1:    div_mag = one_r[29:0];
      default: div_mag = ma_r[29:0];
    endcase
  end

  logic div_done;
  assign div_done = !div_busy_r && !cmd.div_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_go || (div_busy_r && div_cnt_r == 6'd63)) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= 6'd45;
      num_r      <= 45'({div_mag, 14'd0}) + 45'(len >> 1);
      drem_r     <= '0;
      quo_r      <= '0;
      if (cmd.div_go) div_idx_r <= 2'd0;
    end else if (div_busy_r) begin
      if (div_cnt_r != 6'd0) begin
        if (drem_sh >= 32'(len)) begin
          drem_r <= drem_sh - 32'(len);
          quo_r  <= {quo_r[43:0], 1'b1};
        end else begin
          drem_r <= drem_sh;
          quo_r  <= {quo_r[43:0], 1'b0};
        end
        num_r     <= num_r << 1;
        div_cnt_r <= div_cnt_r - 6'd1;
      end else begin
        case (div_idx_r)
          2'd0:    qx_r <= b_pos_r ? 16'(-{1'b0, qsat}) : {1'b0, qsat};
          2'd1:    qy_r <= {1'b0, qsat};
          default: qz_r <= a_pos_r ? 16'(-{1'b0, qsat}) : {1'b0, qsat};
        endcase
        if (div_idx_r == 2'd2) begin
          div_busy_r <= 1'b0;
        end else begin
          div_idx_r <= div_idx_r + 2'd1;
          div_cnt_r <= 6'd63;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status   <= cmd.out_zero ? oob : 1'b0;
      out_normal_x <= cmd.out_zero ? '0 : qx_r;
      out_normal_y <= cmd.out_zero ? '0 : qy_r[14:0];
      out_normal_z <= cmd.out_zero ? '0 : qz_r;
    end
  end

  assign sts.mode       = mode_r;
  assign sts.oob        = oob;
  assign sts.shift_done = shift_done;
  assign sts.sqrt_done  = sqrt_done;
  assign sts.div_done   = div_done;

endmodule
`default_nettype wire

// ===== hdl/heightmap_surface_normal_core.sv =====
// Writes and out-of-grid items give their result from the decide state that follows acceptance;
// queries pass through the neighbour reads, the normalizing shift, the bit-serial square root
// (31 steps) and the shared divider (45 steps per component). A new item is accepted only
// once the controller is back in idle and the result register is free to be refilled.
// rst_n is synchronous, active low: it clears control state and restores the configuration
// registers to 256 rows, 256 columns and slope gain 128; the height memory is not cleared.
`default_nettype none
module heightmap_surface_normal_core
  import hmsn_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_row,
  input  wire logic [7:0]  in_col,
  input  wire logic [15:0] in_height,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        out_status,
  output      logic [15:0] out_normal_x,
  output      logic [14:0] out_normal_y,
  output      logic [15:0] out_normal_z,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [8:0]  grid_rows_r, grid_cols_r;
  logic [15:0] slope_gain_r;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r  <= 9'd256;
      grid_cols_r  <= 9'd256;
      slope_gain_r <= 16'd128;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRID_ROWS:  grid_rows_r  <= cfg_data[8:0];
        CFG_GRID_COLS:  grid_cols_r  <= cfg_data[8:0];
        CFG_SLOPE_GAIN: slope_gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  hmsn_cmd_t cmd;
  hmsn_sts_t sts;

  hmsn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  hmsn_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (in_mode),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_height    (in_height),
    .grid_rows    (grid_rows_r),
    .grid_cols    (grid_cols_r),
    .slope_gain   (slope_gain_r),
    .out_status   (out_status),
    .out_normal_x (out_normal_x),
    .out_normal_y (out_normal_y),
    .out_normal_z (out_normal_z)
  );

endmodule
`default_nettype wire
